/* hw/rtl/masked_byte_signature_scan_macros.svh */
// Assertion macros used by the checker of the masked byte signature scanner.
`ifndef MASKED_BYTE_SIGNATURE_SCAN_MACROS_SVH
`define MASKED_BYTE_SIGNATURE_SCAN_MACROS_SVH

// Same-cycle implication, sampled on i_clk and switched off while i_rst_n is low.
`define MBSS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mbss: same-cycle check failed");

// Next-cycle implication, sampled on i_clk and switched off while i_rst_n is low.
`define MBSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mbss: next-cycle check failed");

`endif

/* hw/rtl/mbss_pkg.sv */
// Shared types and constants of the masked byte signature scanner.
`default_nettype none

package mbss_pkg;

    localparam int MAX_PATTERN_DEF   = 128;
    localparam int POSITION_BITS_DEF = 32;

    localparam int BYTE_W     = 8;
    localparam int ENTRY_W    = 7;
    localparam int OUT_POS_W  = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_SCAN = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 1'b0,
        CFG_PATCH_OFFSET   = 1'b1
    } t_cfg_idx;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic load;     // write the selected cell's pattern entry
        logic shift;    // move the window one cell along
        logic advance;  // step the prefix-match bits with the broadcast byte
        logic clear;    // drop all prefix-match bits
    } t_cell_ctrl;

endpackage

`default_nettype wire

/* hw/rtl/mbss_if.sv */
// Handshake channel interfaces of the masked byte signature scanner.
`default_nettype none

interface mbss_in_if;
    import mbss_pkg::*;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [ENTRY_W-1:0]  entry_index;
    logic [BYTE_W-1:0]   data_byte;
    logic                must_match;
    logic                last_byte;

    modport source (output valid, kind, entry_index, data_byte, must_match, last_byte,
                    input ready);
    modport sink   (input valid, kind, entry_index, data_byte, must_match, last_byte,
                    output ready);
endinterface

interface mbss_out_if;
    import mbss_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [OUT_POS_W-1:0] match_position;
    logic [OUT_POS_W-1:0] patch_position;

    modport source (output valid, found, match_position, patch_position, input ready);
    modport sink   (input valid, found, match_position, patch_position, output ready);
endinterface

interface mbss_cfg_if;
    import mbss_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/masked_byte_signature_scan.sv */
// Top level of the masked byte signature scanner: cell chain, sequencer and result register.
//
//   Channel  | Direction | Handshake     | Payload
//   ---------+-----------+---------------+-------------------------------------------------
//   i_in     | in        | valid / ready | kind, entry_index, data_byte, must_match,
//            |           |               | last_byte
//   i_cfg    | in        | valid / ready | index, data (pattern_length, patch_offset)
//   o_res    | out       | valid / ready | found, match_position, patch_position
//
// A scan byte, or a pattern load before any byte of the buffer, leaves the sequencer ready
// for the next item. After the final byte of a buffer the sequencer takes no item while it
// moves the result into the output register, and it waits while an earlier result is still
// not taken. A pattern load in the middle of a buffer is followed by a rotation of the
// window once through the chain to rebuild the prefix-match bits.
// Reset (i_rst_n low at a clock edge) clears the scan state and the output valid; the
// pattern entries are undefined until loaded, and there is no clearing pass.
`default_nettype none

module masked_byte_signature_scan #(
    parameter int MAX_PATTERN   = mbss_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = mbss_pkg::POSITION_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mbss_in_if.sink           i_in,
    mbss_cfg_if.sink          i_cfg,
    mbss_out_if.source        o_res
);
    import mbss_pkg::*;

    // Widths that follow from the parameters.
    localparam int POS_W = POSITION_BITS;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int P_W   = POS_W + 2;

    localparam logic [IDX_W-1:0] RCNT_LAST = IDX_W'(MAX_PATTERN - 1);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_PATTERN);

    // The sequencer: taking items, rotating the window after a mid-buffer load, and
    // handing a finished result to the output register.
    typedef enum logic [2:0] {
        ST_RUN    = 3'b001,
        ST_REPORT = 3'b010,
        ST_REPLAY = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [POS_W-1:0]  r_seen, n_seen;
    logic              r_latched, n_latched;
    logic [POS_W-1:0]  r_start, n_start;
    logic [IDX_W-1:0]  r_rcnt, n_rcnt;
    logic [IDX_W-1:0]  r_skip, n_skip;
    logic [7:0]        r_len, n_len;
    logic [7:0]        r_off, n_off;

    logic                 r_out_valid, n_out_valid;
    logic                 r_found, n_found;
    logic [OUT_POS_W-1:0] r_mpos, n_mpos;
    logic [OUT_POS_W-1:0] r_ppos, n_ppos;

    t_cell_ctrl        ctrl;
    logic [BYTE_W-1:0] feed_byte;
    logic [BYTE_W-1:0] win   [MAX_PATTERN];
    logic              m     [MAX_PATTERN];
    logic              m_adv [MAX_PATTERN];

    logic              in_acc;
    logic              is_scan;
    logic [LEN_W-1:0]  len_eff;
    logic [IDX_W-1:0]  sel_idx;
    logic              sel_match;
    logic              seen_full;
    logic [POS_W-1:0]  seen_inc;
    logic              seen_ge_max;
    logic [LEN_W-1:0]  skip_full;
    logic [IDX_W-1:0]  skip_val;
    logic [P_W-1:0]    patch_sum;
    logic [POS_W-1:0]  patch_clamped;

    assign in_acc  = i_in.valid && i_in.ready;
    assign is_scan = (t_kind'(i_in.kind) == KIND_SCAN);

    // Items are taken only while the sequencer is free; configuration is always taken.
    assign i_in.ready  = (r_state == ST_RUN);
    assign i_cfg.ready = 1'b1;

    // Length in use: zero counts as one, anything above the chain length saturates.
    always_comb begin
        priority if (r_len == 8'd0) begin
            len_eff = LEN_W'(1);
        end else if ({1'b0, r_len} > 9'(MAX_PATTERN)) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = LEN_W'(r_len);
        end
    end

    // Cell k holds the prefix bit for length k + 1, so the full signature is read from
    // the cell at position length - 1, as it would be after this byte.
    assign sel_idx   = IDX_W'(len_eff - LEN_W'(1));
    assign sel_match = m_adv[sel_idx];

    assign seen_full = (r_seen == {POS_W{1'b1}});
    assign seen_inc  = r_seen + POS_W'(1);

    // Only the bytes actually seen in this buffer are replayed; older window cells are
    // skipped at the start of the rotation.
    assign seen_ge_max = ({1'b0, r_seen} >= (POS_W + 1)'(MAX_PATTERN));
    assign skip_full   = LEN_MAX - LEN_W'(r_seen);
    assign skip_val    = seen_ge_max ? '0 : skip_full[IDX_W-1:0];

    // During a rotation the oldest byte goes back in at the head of the chain.
    assign feed_byte = (r_state == ST_REPLAY) ? win[MAX_PATTERN-1] : i_in.data_byte;

    // Patch position: match start plus length plus the signed offset, clamped to the
    // range of a position. Two spare bits hold the sign and the overshoot.
    assign patch_sum = {2'b00, r_start}
                     + P_W'(len_eff)
                     + {{(P_W - 8){r_off[7]}}, r_off};

    always_comb begin
        priority if (patch_sum[P_W-1]) begin
            patch_clamped = '0;
        end else if (patch_sum[POS_W]) begin
            patch_clamped = {POS_W{1'b1}};
        end else begin
            patch_clamped = patch_sum[POS_W-1:0];
        end
    end

    // The chain of cells. Cell 0 sees the newest byte; the prefix bit of length zero is
    // always true.
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic              sel;
        logic [BYTE_W-1:0] win_in;
        logic              m_in;

        if (k < (1 << ENTRY_W)) begin : g_sel
            assign sel = (i_in.entry_index == ENTRY_W'(k));
        end else begin : g_nosel
            assign sel = 1'b0;
        end

        if (k == 0) begin : g_head
            assign win_in = feed_byte;
            assign m_in   = 1'b1;
        end else begin : g_body
            assign win_in = win[k-1];
            assign m_in   = m[k-1];
        end

        mbss_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_sel       (sel),
            .i_load_byte (i_in.data_byte),
            .i_load_must (i_in.must_match),
            .i_byte      (feed_byte),
            .i_win       (win_in),
            .o_win       (win[k]),
            .i_m         (m_in),
            .o_m         (m[k]),
            .o_m_adv     (m_adv[k])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_seen      = r_seen;
        n_latched   = r_latched;
        n_start     = r_start;
        n_rcnt      = r_rcnt;
        n_skip      = r_skip;
        n_len       = r_len;
        n_off       = r_off;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_mpos      = r_mpos;
        n_ppos      = r_ppos;
        ctrl        = '0;

        // A result leaves the output register when the sink takes it.
        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_PATTERN_LENGTH: n_len = i_cfg.data;
                CFG_PATCH_OFFSET:   n_off = i_cfg.data;
                default:            n_len = r_len;
            endcase
        end

        unique case (r_state)
            ST_RUN: begin
                if (in_acc) begin
                    if (is_scan) begin
                        ctrl.shift   = 1'b1;
                        ctrl.advance = 1'b1;
                        // Once the byte count saturates, bytes still enter the window
                        // but no further match is latched.
                        if (!seen_full) begin
                            n_seen = seen_inc;
                            if (!r_latched && sel_match) begin
                                n_latched = 1'b1;
                                n_start   = seen_inc - POS_W'(len_eff);
                            end
                        end
                        if (i_in.last_byte) begin
                            n_state = ST_REPORT;
                        end
                    end else begin
                        ctrl.load = 1'b1;
                        // A new entry invalidates the prefix bits of a buffer in
                        // progress: drop them and rebuild from the window.
                        if (r_seen != '0) begin
                            ctrl.clear = 1'b1;
                            n_rcnt     = '0;
                            n_skip     = skip_val;
                            n_state    = ST_REPLAY;
                        end
                    end
                end
            end
            ST_REPLAY: begin
                ctrl.shift   = 1'b1;
                ctrl.advance = (r_rcnt >= r_skip);
                n_rcnt       = r_rcnt + IDX_W'(1);
                if (r_rcnt == RCNT_LAST) begin
                    n_state = ST_RUN;
                end
            end
            ST_REPORT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_found     = r_latched;
                    n_mpos      = r_latched ? OUT_POS_W'(r_start) : '0;
                    n_ppos      = r_latched ? OUT_POS_W'(patch_clamped) : '0;
                    // Start the next buffer from a clean scan state.
                    ctrl.clear  = 1'b1;
                    n_seen      = '0;
                    n_latched   = 1'b0;
                    n_start     = '0;
                    n_state     = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_seen      <= '0;
            r_latched   <= 1'b0;
            r_start     <= '0;
            r_rcnt      <= '0;
            r_skip      <= '0;
            r_len       <= 8'd1;
            r_off       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_latched   <= n_latched;
            r_start     <= n_start;
            r_rcnt      <= n_rcnt;
            r_skip      <= n_skip;
            r_len       <= n_len;
            r_off       <= n_off;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found <= n_found;
        r_mpos  <= n_mpos;
        r_ppos  <= n_ppos;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.found          = r_found;
    assign o_res.match_position = r_mpos;
    assign o_res.patch_position = r_ppos;

endmodule

`default_nettype wire

/* hw/rtl/mbss_cell.sv */
// One cell of the scan chain: a pattern entry, a window byte and a prefix-match bit.
`default_nettype none

module mbss_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mbss_pkg::t_cell_ctrl         i_ctrl,
    input  logic                         i_sel,
    input  logic [mbss_pkg::BYTE_W-1:0]  i_load_byte,
    input  logic                         i_load_must,
    input  logic [mbss_pkg::BYTE_W-1:0]  i_byte,
    input  logic [mbss_pkg::BYTE_W-1:0]  i_win,
    output logic [mbss_pkg::BYTE_W-1:0]  o_win,
    input  logic                         i_m,
    output logic                         o_m,
    output logic                         o_m_adv
);
    import mbss_pkg::*;

    logic [BYTE_W-1:0] r_pat;
    logic              r_must;
    logic [BYTE_W-1:0] r_win;
    logic              r_m;
    logic              n_m;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && i_sel) begin
            r_pat  <= i_load_byte;
            r_must <= i_load_must;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_win <= i_win;
        end
    end

    // The prefix one longer than the neighbour's holds if this entry agrees or is a wildcard.
    assign o_m_adv = i_m && (!r_must || (i_byte == r_pat));

    always_comb begin
        n_m = r_m;
        priority if (i_ctrl.clear) begin
            n_m = 1'b0;
        end else if (i_ctrl.advance) begin
            n_m = o_m_adv;
        end else begin
            n_m = r_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m <= 1'b0;
        end else begin
            r_m <= n_m;
        end
    end

    assign o_win = r_win;
    assign o_m   = r_m;

endmodule

`default_nettype wire

/* hw/rtl/mbss_checker.sv */
// Port-level checks of the masked byte signature scanner and their binding.
`default_nettype none
`include "masked_byte_signature_scan_macros.svh"

module mbss_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             i_in_ready,
    input wire logic                             i_in_kind,
    input wire logic                             i_in_last_byte,
    input wire logic                             i_out_valid,
    input wire logic                             i_out_ready,
    input wire logic                             i_out_found,
    input wire logic [mbss_pkg::OUT_POS_W-1:0]   i_out_match_position,
    input wire logic [mbss_pkg::OUT_POS_W-1:0]   i_out_patch_position
);
    import mbss_pkg::*;

    logic last_scan_acc;

    assign last_scan_acc = i_in_valid && i_in_ready && i_in_last_byte
                        && (t_kind'(i_in_kind) == KIND_SCAN);

    // A result waiting on the sink holds its value.
    `MBSS_ASSERT_NEXT(a_out_hold, (i_out_valid && !i_out_ready),
        (i_out_valid && $stable(i_out_found) && $stable(i_out_match_position)
         && $stable(i_out_patch_position)))

    // A result without a match reports both positions as zero.
    `MBSS_ASSERT_SAME(a_miss_zero, (i_out_valid && !i_out_found),
        ((i_out_match_position == '0) && (i_out_patch_position == '0)))

    // The final byte of a buffer is followed by a cycle in which no item is taken.
    `MBSS_ASSERT_NEXT(a_last_blocks, last_scan_acc, !i_in_ready)

    // A new result only appears after such a blocked cycle.
    `MBSS_ASSERT_SAME(a_result_after_block, $rose(i_out_valid), !$past(i_in_ready))

endmodule

bind masked_byte_signature_scan mbss_checker u_mbss_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in.valid),
    .i_in_ready           (i_in.ready),
    .i_in_kind            (i_in.kind),
    .i_in_last_byte       (i_in.last_byte),
    .i_out_valid          (o_res.valid),
    .i_out_ready          (o_res.ready),
    .i_out_found          (o_res.found),
    .i_out_match_position (o_res.match_position),
    .i_out_patch_position (o_res.patch_position)
);

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the masked byte signature scanner, driven through its channels.
`timescale 1ns / 100ps

module tb;
    import mbss_pkg::*;

    localparam int MAXP          = MAX_PATTERN_DEF;
    // A pattern load in the middle of a buffer keeps the block busy rotating the window
    // without producing a result, so every quiet point waits longer than that rotation.
    localparam int SETTLE_CYCLES = MAXP + 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int STIM_ITEMS    = 1800;
    localparam logic [OUT_POS_W-1:0] POS_LIMIT = '1;

    // One input transaction as the block sees it.
    typedef struct packed {
        t_kind               kind;
        logic [ENTRY_W-1:0]  entry_index;
        logic [BYTE_W-1:0]   data_byte;
        logic                must_match;
        logic                last_byte;
    } t_scan_item;

    // One result transaction, reported on the final byte of a buffer.
    typedef struct packed {
        logic                 found;
        logic [OUT_POS_W-1:0] match_position;
        logic [OUT_POS_W-1:0] patch_position;
    } t_scan_report;

    // A row of the directed table: either a register write or an input transaction,
    // with the result typed in where it is obvious.
    typedef struct {
        bit                 cfg;
        t_cfg_idx           reg_sel;
        t_kind              kind;
        logic [ENTRY_W-1:0] index;
        logic [BYTE_W-1:0]  data;
        logic               must;
        logic               last;
        bit                 typed;
        t_scan_report       want;
    } t_row;

    logic clk = 1'b0;
    logic rst_n;

    mbss_in_if  in_ch ();
    mbss_cfg_if cfg_ch ();
    mbss_out_if res_ch ();

    masked_byte_signature_scan DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------------------
    // Predictor state: the signature entries, the window of recent bytes (index 0 is the
    // newest), the byte counter and the latched first match, plus both registers.
    // ------------------------------------------------------------------------------------
    bit [BYTE_W-1:0]    sig_byte   [MAXP];
    bit                 sig_cmp    [MAXP];
    bit                 sig_loaded [MAXP];
    bit [BYTE_W-1:0]    win_byte   [MAXP];
    bit [OUT_POS_W-1:0] seen_count;
    bit                 hit_latched;
    bit [OUT_POS_W-1:0] hit_start;
    bit [7:0]           len_reg    = 8'd1;
    bit [7:0]           offset_reg = 8'd0;

    t_scan_report pending_reports [$];
    t_row         directed_rows [$];
    int           items_sent;
    int           mismatches;

    // Stimulus shaping, shared between the sender and the receiver.
    bit           burst_mode;
    bit           hold_results;
    int           wild_pct;
    logic [7:0]   byte_mask = 8'hFF;

    // A length of zero behaves as one, and anything above the store depth saturates.
    function automatic int active_len();
        if (len_reg == 8'd0)
            return 1;
        if (int'(len_reg) > MAXP)
            return MAXP;
        return int'(len_reg);
    endfunction

    // Advances the predicted state by one accepted transaction; returns 1 when the
    // transaction produces a result, which is then left in rep.
    function automatic bit scan_predict(input t_scan_item it, output t_scan_report rep);
        int     n;
        int     k;
        bit     hit;
        longint spot;
        n = active_len();
        rep = '0;
        if (it.kind == KIND_LOAD) begin
            sig_byte[it.entry_index]   = it.data_byte;
            sig_cmp[it.entry_index]    = it.must_match;
            sig_loaded[it.entry_index] = 1'b1;
            return 1'b0;
        end
        for (k = MAXP - 1; k > 0; k--)
            win_byte[k] = win_byte[k - 1];
        win_byte[0] = it.data_byte;
        // The counter saturates; bytes after that still enter the window uncompared.
        if (seen_count != POS_LIMIT) begin
            seen_count++;
            if (!hit_latched && seen_count >= n) begin
                hit = 1'b1;
                for (k = 0; k < n; k++)
                    if (sig_cmp[k] && win_byte[n - 1 - k] != sig_byte[k])
                        hit = 1'b0;
                if (hit) begin
                    hit_latched = 1'b1;
                    hit_start   = seen_count - OUT_POS_W'(n);
                end
            end
        end
        if (!it.last_byte)
            return 1'b0;
        if (hit_latched) begin
            spot = longint'(hit_start) + longint'(n) + longint'($signed(offset_reg));
            rep.found          = 1'b1;
            rep.match_position = hit_start;
            if (spot < 0)
                rep.patch_position = '0;
            else if (spot > longint'(POS_LIMIT))
                rep.patch_position = POS_LIMIT;
            else
                rep.patch_position = spot[OUT_POS_W-1:0];
        end
        for (k = 0; k < MAXP; k++)
            win_byte[k] = '0;
        seen_count  = '0;
        hit_latched = 1'b0;
        hit_start   = '0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom) & byte_mask;
    endfunction

    // ------------------------------------------------------------------------------------
    // Sender. Each transaction waits a drawn number of cycles, then holds valid until the
    // block takes it. Valid stays high straight into the next transaction when no gap is
    // drawn, so it is never lowered and raised within one time step.
    // ------------------------------------------------------------------------------------
    task automatic push_item(input t_scan_item it, input bit typed, input t_scan_report want);
        int           gap;
        t_scan_report rep;
        gap = burst_mode ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= it.kind;
        in_ch.entry_index <= it.entry_index;
        in_ch.data_byte   <= it.data_byte;
        in_ch.must_match  <= it.must_match;
        in_ch.last_byte   <= it.last_byte;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        items_sent++;
        if (scan_predict(it, rep))
            pending_reports.push_back(typed ? want : rep);
    endtask

    // Stops offering input, waits for every outstanding result and then lets a possible
    // window rebuild run out, so that the block is idle on return.
    task automatic settle_block();
        in_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the caller makes sure the block is idle.
    task automatic write_reg(input t_cfg_idx sel, input logic [7:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= sel;
        cfg_ch.data  <= val;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        if (sel == CFG_PATTERN_LENGTH)
            len_reg = val;
        else
            offset_reg = val;
    endtask

    // Loads one signature entry with a random byte; the wildcard share follows the phase.
    task automatic load_entry(input int j);
        t_scan_item it;
        it.kind        = KIND_LOAD;
        it.entry_index = ENTRY_W'(j);
        it.data_byte   = rand_byte();
        it.must_match  = ($urandom_range(0, 99) >= wild_pct);
        it.last_byte   = 1'($urandom);
        push_item(it, 1'b0, '0);
    endtask

    // Entries that were never written must not take part in a compare.
    task automatic load_missing();
        int j;
        for (j = 0; j < active_len(); j++)
            if (!sig_loaded[j])
                load_entry(j);
    endtask

    // Builds one buffer around the current signature and streams it in. Most buffers
    // carry the signature with random wildcard bytes, some with one byte spoiled, some
    // are too short to match, and the rest are random bytes. Now and then an entry is
    // reloaded in the middle of the buffer, or the registers are retuned mid-buffer.
    task automatic send_buffer();
        logic [7:0] bytes [$];
        t_scan_item it;
        int         n;
        int         mode;
        int         j;
        int         k;
        int         reload_at;
        int         retune_at;
        n = active_len();
        mode = $urandom_range(0, 99);
        if (mode < 75) begin
            repeat ($urandom_range(0, 6)) bytes.push_back(rand_byte());
            for (j = 0; j < n; j++)
                bytes.push_back(sig_cmp[j] ? sig_byte[j] : rand_byte());
            if (mode >= 60) begin
                k = bytes.size() - n + $urandom_range(0, n - 1);
                bytes[k] = bytes[k] ^ (8'h01 << $urandom_range(0, 7));
            end
            // Leaving the tail off makes the match end on the final byte.
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 6)) bytes.push_back(rand_byte());
        end else if (mode < 85) begin
            repeat ((n > 1) ? $urandom_range(1, n - 1) : 1) bytes.push_back(rand_byte());
        end else begin
            repeat ($urandom_range(1, n + 12)) bytes.push_back(rand_byte());
        end
        reload_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, bytes.size() - 1) : -1;
        retune_at = ($urandom_range(0, 19) == 0 && bytes.size() > 1) ?
                    $urandom_range(1, bytes.size() - 1) : -1;
        for (k = 0; k < bytes.size(); k++) begin
            if (k == retune_at) begin
                settle_block();
                write_reg(CFG_PATTERN_LENGTH, 8'($urandom_range(1, 8)));
                write_reg(CFG_PATCH_OFFSET, 8'($urandom));
                load_missing();
            end
            if (k == reload_at)
                load_entry($urandom_range(0, active_len() - 1));
            it.kind        = KIND_SCAN;
            it.entry_index = ENTRY_W'($urandom);
            it.data_byte   = bytes[k];
            it.must_match  = 1'($urandom);
            it.last_byte   = (k == bytes.size() - 1);
            push_item(it, 1'b0, '0);
        end
    endtask

    // One phase: program both registers while idle, load a signature, then scan buffers.
    task automatic run_phase(input logic [7:0] len_val, input logic [7:0] off_val);
        int n;
        int j;
        // The sender stops here until every expected result has come back.
        settle_block();
        write_reg(CFG_PATTERN_LENGTH, len_val);
        write_reg(CFG_PATCH_OFFSET, off_val);
        case ($urandom_range(0, 5))
            0:       wild_pct = 100;
            1:       wild_pct = 0;
            default: wild_pct = 25;
        endcase
        case ($urandom_range(0, 3))
            0:       byte_mask = 8'h01;
            1:       byte_mask = 8'h03;
            default: byte_mask = 8'hFF;
        endcase
        n = active_len();
        // Long signatures are only partly reloaded, to keep most of the run on short ones.
        for (j = 0; j < n; j++)
            if (!sig_loaded[j] || n <= 16 || $urandom_range(0, 15) == 0)
                load_entry(j);
        if ($urandom_range(0, 1) == 0)
            load_entry($urandom_range(0, MAXP - 1));
        repeat ((n > 32) ? 2 : $urandom_range(3, 6)) send_buffer();
    endtask

    // ------------------------------------------------------------------------------------
    // Receiver and checker. Ready is withheld for a drawn number of cycles before each
    // result; on request it is withheld for a long stretch so that the result register
    // stays full and the block has to stall its input. Each accepted result transaction
    // is compared field by field with the oldest expected report.
    // ------------------------------------------------------------------------------------
    initial begin : result_sink
        int           wait_cycles;
        t_scan_report want;
        res_ch.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            wait_cycles = burst_mode ? 0 : $urandom_range(0, 15);
            if (hold_results) begin
                hold_results = 1'b0;
                wait_cycles  = HOLD_CYCLES;
            end
            if (wait_cycles > 0) begin
                res_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (res_ch.valid !== 1'b1);
            if (pending_reports.size() == 0) begin
                $error("result with nothing expected: found %0d, match %0d, patch %0d",
                       res_ch.found, res_ch.match_position, res_ch.patch_position);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                if (res_ch.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, res_ch.found);
                    mismatches++;
                end
                if (res_ch.match_position !== want.match_position) begin
                    $error("match_position: expected %0d, got %0d",
                           want.match_position, res_ch.match_position);
                    mismatches++;
                end
                if (res_ch.patch_position !== want.patch_position) begin
                    $error("patch_position: expected %0d, got %0d",
                           want.patch_position, res_ch.patch_position);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Stimulus: reset, the directed table, then random phases until enough transactions
    // have gone in, and finally the drain and the verdict.
    // ------------------------------------------------------------------------------------
    initial begin : stimulus
        t_row         row;
        t_scan_item   it;
        int           phase;
        logic [7:0]   len_val;
        logic [7:0]   off_val;
        rst_n              <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.kind         <= KIND_LOAD;
        in_ch.entry_index  <= '0;
        in_ch.data_byte    <= '0;
        in_ch.must_match   <= 1'b0;
        in_ch.last_byte    <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_PATTERN_LENGTH;
        cfg_ch.data        <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset the length is one and the offset zero; no entry is loaded yet.
        directed_rows = '{
            // A load with last_byte set reports nothing.
            '{1'b0, CFG_PATTERN_LENGTH, KIND_LOAD, 7'd0, 8'hFF, 1'b1, 1'b1, 1'b0, '0},
            // One-byte buffers: an immediate match, then a miss.
            '{1'b0, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd0, 8'hFF, 1'b0, 1'b1, 1'b1,
              {1'b1, 32'd0, 32'd1}},
            '{1'b0, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd127, 8'h00, 1'b1, 1'b1, 1'b1,
              {1'b0, 32'd0, 32'd0}},
            // Only the first of two matches is kept.
            '{1'b0, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd0, 8'h12, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd0, 8'hFF, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd0, 8'hFF, 1'b0, 1'b1, 1'b1,
              {1'b1, 32'd1, 32'd2}},
            // Most negative offset: the patch position clamps at zero.
            '{1'b1, CFG_PATCH_OFFSET, KIND_SCAN, 7'd0, 8'h80, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd0, 8'hFF, 1'b0, 1'b1, 1'b1,
              {1'b1, 32'd0, 32'd0}},
            // Most positive offset.
            '{1'b1, CFG_PATCH_OFFSET, KIND_SCAN, 7'd0, 8'h7F, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd0, 8'hFF, 1'b0, 1'b1, 1'b1,
              {1'b1, 32'd0, 32'd128}},
            // A length of zero behaves as one.
            '{1'b1, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd0, 8'h00, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd0, 8'h00, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd0, 8'hFF, 1'b0, 1'b1, 1'b1,
              {1'b1, 32'd1, 32'd129}},
            // Three-entry signature with a wildcard in the middle; entry 127 is loaded too.
            '{1'b1, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd0, 8'd3, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PATTERN_LENGTH, KIND_LOAD, 7'd0, 8'hA5, 1'b1, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PATTERN_LENGTH, KIND_LOAD, 7'd1, 8'h00, 1'b0, 1'b1, 1'b0, '0},
            '{1'b0, CFG_PATTERN_LENGTH, KIND_LOAD, 7'd2, 8'h5A, 1'b1, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PATTERN_LENGTH, KIND_LOAD, 7'd127, 8'h00, 1'b0, 1'b0, 1'b0, '0},
            // A buffer shorter than the signature never matches.
            '{1'b0, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd0, 8'hA5, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd0, 8'h5A, 1'b0, 1'b1, 1'b1,
              {1'b0, 32'd0, 32'd0}},
            // A match ending on the final byte still counts.
            '{1'b0, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd0, 8'hA5, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd0, 8'h33, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd0, 8'h5A, 1'b0, 1'b1, 1'b1,
              {1'b1, 32'd0, 32'd130}},
            // The length changes in the middle of a buffer and applies from the next byte.
            '{1'b0, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd0, 8'h11, 1'b0, 1'b0, 1'b0, '0},
            '{1'b1, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd0, 8'd1, 1'b0, 1'b0, 1'b0, '0},
            '{1'b0, CFG_PATTERN_LENGTH, KIND_SCAN, 7'd0, 8'hA5, 1'b0, 1'b1, 1'b1,
              {1'b1, 32'd1, 32'd129}}
        };
        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.cfg) begin
                settle_block();
                write_reg(row.reg_sel, row.data);
            end else begin
                it.kind        = row.kind;
                it.entry_index = row.index;
                it.data_byte   = row.data;
                it.must_match  = row.must;
                it.last_byte   = row.last;
                push_item(it, row.typed, row.want);
            end
        end

        // The longest signatures come first: a length beyond the store depth with the most
        // negative offset, then exactly the store depth with the most positive one.
        wild_pct = 25;
        run_phase(8'd255, 8'h80);
        run_phase(8'd128, 8'h7F);

        phase = 0;
        while (items_sent < STIM_ITEMS) begin
            // Two phases run with the receiver holding off for a long stretch while the
            // sender streams without gaps; every fourth phase runs without idling.
            hold_results = (phase == 2 || phase == 9);
            burst_mode   = hold_results || (phase % 4 == 3);
            case ($urandom_range(0, 39))
                0:                   len_val = 8'd0;
                1:                   len_val = 8'($urandom_range(128, 255));
                2, 3, 4, 5, 6, 7:    len_val = 8'($urandom_range(9, 32));
                default:             len_val = 8'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 7))
                0:       off_val = 8'h80;
                1:       off_val = 8'h7F;
                default: off_val = 8'($urandom);
            endcase
            run_phase(len_val, off_val);
            phase++;
        end

        burst_mode = 1'b0;
        settle_block();
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Far beyond the slowest correct run, including every mid-buffer window rebuild.
    initial begin : watchdog
        #(20_000_000);
        $display("tb: FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/mbss_pkg.sv
hw/rtl/mbss_if.sv
hw/rtl/mbss_cell.sv
hw/rtl/masked_byte_signature_scan.sv
hw/rtl/mbss_checker.sv
dv/tb.sv
